FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_CHK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

FILE: rtl/rwcl_pkg.sv
// shared item types and status codes of the wave chunk locator
package rwcl_pkg;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_MISSING_FMT = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN     = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] fmt_offset;
    logic [31:0] fmt_size;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_item_t;

endpackage

FILE: rtl/rwcl_parser.sv
// chunk walker: parser state registers and per-byte next-state logic
module rwcl_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  rwcl_pkg::byte_item_t  item,
  output logic                  res_valid,
  output rwcl_pkg::result_item_t res_item
);

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_SIZE = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_RIFF = 2'd0;
  localparam logic [1:0] KIND_SKIP = 2'd1;
  localparam logic [1:0] KIND_FMT  = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FACT = 32'h7463_6166;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_WAVH = 32'h6876_6177;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_GUID = 32'h6469_7567;

  phase_t      phase, phase_cur, phase_next;
  logic [31:0] byte_count, count_cur, byte_count_next;
  logic [31:0] word_shift, shift_cur, word_shift_next;
  logic [1:0]  field_bytes, fbytes_cur, field_bytes_next;
  logic [1:0]  chunk_kind, kind_cur, chunk_kind_next;
  logic [31:0] skip_left, skip_cur, skip_left_next;
  logic [31:0] fmt_start, fstart_cur, fmt_start_next;
  logic [31:0] fmt_length, flen_cur, fmt_length_next;
  logic        fmt_found, found_cur, fmt_found_next;
  logic        parse_done, done_cur, parse_done_next;

  always_comb begin
    // a first mark restarts from the reset state
    phase_cur  = item.first ? PH_ID : phase;
    count_cur  = item.first ? '0 : byte_count;
    shift_cur  = item.first ? '0 : word_shift;
    fbytes_cur = item.first ? '0 : field_bytes;
    kind_cur   = item.first ? KIND_RIFF : chunk_kind;
    skip_cur   = item.first ? '0 : skip_left;
    fstart_cur = item.first ? '0 : fmt_start;
    flen_cur   = item.first ? '0 : fmt_length;
    found_cur  = item.first ? 1'b0 : fmt_found;
    done_cur   = item.first ? 1'b0 : parse_done;

    phase_next       = phase_cur;
    byte_count_next  = count_cur;
    word_shift_next  = shift_cur;
    field_bytes_next = fbytes_cur;
    chunk_kind_next  = kind_cur;
    skip_left_next   = skip_cur;
    fmt_start_next   = fstart_cur;
    fmt_length_next  = flen_cur;
    fmt_found_next   = found_cur;
    parse_done_next  = done_cur;

    res_valid            = 1'b0;
    res_item.status      = rwcl_pkg::STATUS_OK;
    res_item.fmt_offset  = fstart_cur;
    res_item.fmt_size    = flen_cur;
    res_item.data_offset = '0;
    res_item.data_size   = '0;

    if (!done_cur) begin
      byte_count_next = (count_cur == '1) ? count_cur : count_cur + 32'd1;
      if (phase_cur == PH_SKIP) begin
        skip_left_next = skip_cur - 32'd1;
        if (skip_left_next == '0) begin
          phase_next = PH_ID;
        end
      end else begin
        word_shift_next  = {item.data_byte, shift_cur[31:8]};
        field_bytes_next = fbytes_cur + 2'd1;
        if (field_bytes_next == 2'd0) begin
          if (phase_cur == PH_ID) begin
            unique case (word_shift_next)
              ID_RIFF: begin
                chunk_kind_next = KIND_RIFF;
                phase_next      = PH_SIZE;
              end
              ID_WAVE: begin
              end
              ID_FACT, ID_WAVH, ID_GUID: begin
                chunk_kind_next = KIND_SKIP;
                phase_next      = PH_SIZE;
              end
              ID_FMT: begin
                chunk_kind_next = KIND_FMT;
                phase_next      = PH_SIZE;
              end
              ID_DATA: begin
                chunk_kind_next = KIND_DATA;
                phase_next      = PH_SIZE;
              end
              default: begin
                res_valid       = 1'b1;
                res_item.status = rwcl_pkg::STATUS_UNKNOWN;
                parse_done_next = 1'b1;
              end
            endcase
          end else if (kind_cur == KIND_DATA) begin
            res_valid            = 1'b1;
            res_item.status      = found_cur ? rwcl_pkg::STATUS_OK
                                             : rwcl_pkg::STATUS_MISSING_FMT;
            res_item.data_offset = byte_count_next;
            res_item.data_size   = word_shift_next;
            parse_done_next      = 1'b1;
          end else if (kind_cur == KIND_RIFF) begin
            phase_next = PH_ID;
          end else begin
            if (kind_cur == KIND_FMT) begin
              fmt_start_next  = byte_count_next;
              fmt_length_next = word_shift_next;
              fmt_found_next  = 1'b1;
            end
            if (word_shift_next == '0) begin
              phase_next = PH_ID;
            end else begin
              skip_left_next = word_shift_next;
              phase_next     = PH_SKIP;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ID;
      byte_count  <= '0;
      word_shift  <= '0;
      field_bytes <= '0;
      chunk_kind  <= KIND_RIFF;
      skip_left   <= '0;
      fmt_start   <= '0;
      fmt_length  <= '0;
      fmt_found   <= 1'b0;
      parse_done  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      word_shift  <= word_shift_next;
      field_bytes <= field_bytes_next;
      chunk_kind  <= chunk_kind_next;
      skip_left   <= skip_left_next;
      fmt_start   <= fmt_start_next;
      fmt_length  <= fmt_length_next;
      fmt_found   <= fmt_found_next;
      parse_done  <= parse_done_next;
    end
  end

endmodule

FILE: rtl/rwcl_out_buf.sv
// two-entry result register with skid slot
module rwcl_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rwcl_pkg::result_item_t push_item,
  output logic                   full,
  output logic                   valid,
  input  logic                   stall,
  output rwcl_pkg::result_item_t item
);

  logic                   skid_valid;
  rwcl_pkg::result_item_t skid_item;
  logic                   pop;

  assign pop  = valid && !stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!valid || pop) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        item       <= skid_item;
        skid_valid <= 1'b0;
      end else begin
        valid <= push;
        if (push) begin
          item <= push_item;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_item  <= push_item;
    end
  end

endmodule

FILE: rtl/riff_wave_chunk_locator.sv
// top level of the wave chunk locator: byte parser and result buffer
//
//   channel  | direction | payload           | handshake
//   ---------+-----------+-------------------+------------------------------
//   byte     | in        | byte_item_t       | byte_valid / byte_stall
//   result   | out       | result_item_t     | result_valid / result_stall
//
// one byte item can be taken every cycle while byte_stall is low; the parser
// state updates at the accepting edge, and a result, if any, is written at
// that edge into the result register, or the skid slot if it holds a stalled
// result, and in the register it shows on result_valid in the next cycle
// sync reset clears the parser to the read-chunk-id phase and empties the
// result buffer; byte_stall rises only when both result slots hold items, so
// a stalled result side takes one more result item before byte input stops;
// bytes that make no result keep flowing until then
module riff_wave_chunk_locator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  rwcl_pkg::byte_item_t   byte_item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output rwcl_pkg::result_item_t result_item
);

  logic                   accept;
  logic                   res_valid;
  rwcl_pkg::result_item_t res_item;
  logic                   buf_full;

  // a byte goes in whenever the skid slot is free
  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = buf_full;

  // chunk walker: ids, size fields, payload skips, offset bookkeeping
  rwcl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // result register plus skid slot, parts the byte side from the result side
  rwcl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_item (res_item),
    .full      (buf_full),
    .valid     (result_valid),
    .stall     (result_stall),
    .item      (result_item)
  );

endmodule

FILE: rtl/rwcl_checker.sv
// port-level checks of the wave chunk locator and their bind
`include "assert_macros.svh"

module rwcl_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input rwcl_pkg::result_item_t result_item
);

  `ASSERT_CHK(a_result_holds, clk, rst, result_valid && result_stall |=> result_valid)
  `ASSERT_CHK(a_stall_needs_result, clk, rst, byte_stall |-> result_valid)
  `ASSERT_CHK(a_unknown_no_data, clk, rst, result_valid && result_item.status == rwcl_pkg::STATUS_UNKNOWN |-> result_item.data_offset == '0 && result_item.data_size == '0)
  `ASSERT_CHK(a_missing_fmt_zero, clk, rst, result_valid && result_item.status == rwcl_pkg::STATUS_MISSING_FMT |-> result_item.fmt_offset == '0 && result_item.fmt_size == '0)
  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !result_valid && !byte_stall)

endmodule

bind riff_wave_chunk_locator rwcl_checker u_rwcl_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
